// ----- rtl/scmd_pkg.sv -----
// shared types and constants for the speech synth command stream parser
package scmd_pkg;

  localparam int unsigned MAX_DIGITS = 15;
  localparam int unsigned DCNT_W     = 4;
  localparam int unsigned PARAM_W    = 16;
  localparam int unsigned LEVEL_W    = 4;

  localparam logic [7:0] BYTE_CMD   = 8'h01;
  localparam logic [7:0] BYTE_STOP  = 8'h18;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_PLUS  = 8'h2b;
  localparam logic [7:0] BYTE_MINUS = 8'h2d;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam logic [7:0] LETTER_RESET = 8'h40;
  localparam logic [7:0] LETTER_PUNCT = 8'h62;
  localparam logic [7:0] LETTER_VOICE = 8'h6f;
  localparam logic [7:0] LETTER_PITCH = 8'h70;
  localparam logic [7:0] LETTER_RATE  = 8'h73;

  localparam logic [PARAM_W-1:0] PARAM_MAX = '1;
  localparam logic [LEVEL_W-1:0] PITCH_TOP = 4'd10;
  localparam logic [LEVEL_W-1:0] RATE_TOP  = 4'd9;
  localparam logic [LEVEL_W-1:0] LEVEL_MID = 4'd5;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_t;

  typedef enum logic [3:0] {
    KIND_TEXT  = 4'd0,
    KIND_STOP  = 4'd1,
    KIND_RESET = 4'd2,
    KIND_PUNCT = 4'd3,
    KIND_VOICE = 4'd4,
    KIND_PITCH = 4'd5,
    KIND_RATE  = 4'd6,
    KIND_BAD   = 4'd7,
    KIND_UNSUP = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       text_byte;
    logic signed [7:0] setting;
  } result_t;

endpackage

// ----- rtl/scmd_exec.sv -----
// command execution: decodes a command letter and updates pitch and rate levels
module scmd_exec import scmd_pkg::*; (
  input  logic [7:0]         letter,
  input  logic [PARAM_W-1:0] param,
  input  sign_t              sign,
  input  logic [LEVEL_W-1:0] pitch_level,
  input  logic [LEVEL_W-1:0] rate_level,
  output result_t            result,
  output logic [LEVEL_W-1:0] pitch_level_next,
  output logic [LEVEL_W-1:0] rate_level_next
);

  function automatic logic [LEVEL_W-1:0] move_level(
    input logic [LEVEL_W-1:0] level,
    input logic [PARAM_W-1:0] amount,
    input sign_t              dir,
    input logic [LEVEL_W-1:0] top
  );
    logic [PARAM_W:0] sum;
    logic [LEVEL_W-1:0] lvl;
    sum = {{(PARAM_W+1-LEVEL_W){1'b0}}, level} + {1'b0, amount};
    if (dir == SIGN_NONE) begin
      lvl = (amount > {{(PARAM_W-LEVEL_W){1'b0}}, top}) ? top : amount[LEVEL_W-1:0];
    end else if (dir == SIGN_PLUS) begin
      lvl = (sum > {{(PARAM_W+1-LEVEL_W){1'b0}}, top}) ? top : sum[LEVEL_W-1:0];
    end else begin
      lvl = (amount > {{(PARAM_W-LEVEL_W){1'b0}}, level}) ? '0
          : level - amount[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

  // (level - 5) * 20
  function automatic logic signed [7:0] pitch_setting(input logic [LEVEL_W-1:0] lvl);
    logic signed [7:0] s;
    case (lvl)
      4'd0:    s = -8'sd100;
      4'd1:    s = -8'sd80;
      4'd2:    s = -8'sd60;
      4'd3:    s = -8'sd40;
      4'd4:    s = -8'sd20;
      4'd5:    s = 8'sd0;
      4'd6:    s = 8'sd20;
      4'd7:    s = 8'sd40;
      4'd8:    s = 8'sd60;
      4'd9:    s = 8'sd80;
      default: s = 8'sd100;
    endcase
    return s;
  endfunction

  // level * 22 - 100
  function automatic logic signed [7:0] rate_setting(input logic [LEVEL_W-1:0] lvl);
    logic signed [7:0] s;
    case (lvl)
      4'd0:    s = -8'sd100;
      4'd1:    s = -8'sd78;
      4'd2:    s = -8'sd56;
      4'd3:    s = -8'sd34;
      4'd4:    s = -8'sd12;
      4'd5:    s = 8'sd10;
      4'd6:    s = 8'sd32;
      4'd7:    s = 8'sd54;
      4'd8:    s = 8'sd76;
      default: s = 8'sd98;
    endcase
    return s;
  endfunction

  logic [LEVEL_W-1:0] pitch_moved;
  logic [LEVEL_W-1:0] rate_moved;

  assign pitch_moved = move_level(pitch_level, param, sign, PITCH_TOP);
  assign rate_moved  = move_level(rate_level, param, sign, RATE_TOP);

  always_comb begin
    result           = '{kind: KIND_UNSUP, text_byte: letter, setting: 8'sd0};
    pitch_level_next = pitch_level;
    rate_level_next  = rate_level;
    unique case (letter)
      LETTER_RESET: begin
        result = '{kind: KIND_RESET, text_byte: 8'h00, setting: 8'sd0};
      end
      LETTER_PUNCT: begin
        if (param == '0) begin
          result = '{kind: KIND_PUNCT, text_byte: 8'h00, setting: 8'sd0};
        end else if (param <= PARAM_W'(2)) begin
          result = '{kind: KIND_PUNCT, text_byte: 8'h00, setting: 8'sd1};
        end else if (param == PARAM_W'(3)) begin
          result = '{kind: KIND_PUNCT, text_byte: 8'h00, setting: 8'sd2};
        end else begin
          result = '{kind: KIND_BAD, text_byte: letter, setting: 8'sd0};
        end
      end
      LETTER_VOICE: begin
        if (param <= PARAM_W'(7)) begin
          result = '{kind: KIND_VOICE, text_byte: 8'h00,
                     setting: $signed({5'b0, param[2:0]})};
        end else begin
          result = '{kind: KIND_BAD, text_byte: letter, setting: 8'sd0};
        end
      end
      LETTER_PITCH: begin
        pitch_level_next = pitch_moved;
        result = '{kind: KIND_PITCH, text_byte: 8'h00, setting: pitch_setting(pitch_moved)};
      end
      LETTER_RATE: begin
        rate_level_next = rate_moved;
        result = '{kind: KIND_RATE, text_byte: 8'h00, setting: rate_setting(rate_moved)};
      end
      default: begin
        result = '{kind: KIND_UNSUP, text_byte: letter, setting: 8'sd0};
      end
    endcase
  end

endmodule

// ----- rtl/synth_command_stream_parser_unit.sv -----
// top level of the speech synth inline command stream parser
//
// one raw byte of the synth control stream enters per beat on the s_ side;
// each byte gives zero or one result beat on the m_ side
// s_tdata: the raw byte. m_tuser: result kind. m_tdata: text byte and
// signed setting (punctuation mode, voice, pitch or rate value)
// control bytes below 0x20 other than 0x01 and 0x18 read as spaces; 0x18 is
// a stop, 0x01 opens a command: optional sign, up to 15 digits, a letter
// a taken byte passes the input register, then one pass of parse logic into
// the output register; one byte per cycle is taken in steady state while the
// output register is not blocked by m_tready
// bytes that only advance the command parser (0x01, sign, digits) give no beat
// reset clears the parser to the text phase, forgets the last command and
// sets pitch and rate levels to their middle value 5
// when m_tready is low the output register holds its beat; the input
// register still takes a byte if empty, then s_tready drops until the
// output beat is taken
module synth_command_stream_parser_unit import scmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] text_byte, [15:8] setting
  output logic [3:0]  m_tuser    // [3:0] kind
);

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  // parser state
  phase_t             phase, phase_next;
  sign_t              sign_mode, sign_mode_next;
  logic [DCNT_W-1:0]  digit_count, digit_count_next;
  logic [PARAM_W-1:0] param_accum, param_accum_next;
  logic [7:0]         last_letter, last_letter_next;
  logic [PARAM_W-1:0] last_param, last_param_next;
  logic [LEVEL_W-1:0] pitch_level, pitch_level_next;
  logic [LEVEL_W-1:0] rate_level, rate_level_next;

  // output register
  result_t out_res;

  // parse datapath
  logic [7:0]         c;
  logic               is_digit;
  logic               is_sign_char;
  logic               in_digits;
  logic [DCNT_W-1:0]  dc_eff;
  logic [PARAM_W-1:0] acc_eff;
  sign_t              sign_eff;
  logic [PARAM_W+3:0] acc_grow;
  logic [7:0]         cmd_letter;
  logic [PARAM_W-1:0] cmd_param;
  result_t            cmd_res;
  logic [LEVEL_W-1:0] cmd_pitch_next;
  logic [LEVEL_W-1:0] cmd_rate_next;
  logic               res_valid;
  result_t            res;

  // output register frees up whenever its beat is gone or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // sanitize: control bytes other than command and stop become spaces
  assign c = (in_byte < BYTE_SPACE && in_byte != BYTE_STOP && in_byte != BYTE_CMD)
           ? BYTE_SPACE : in_byte;
  assign is_digit     = (c >= BYTE_ZERO) && (c <= BYTE_NINE);
  assign is_sign_char = (c == BYTE_PLUS) || (c == BYTE_MINUS);

  // the sign position falls through to the digit position when no sign is there
  assign in_digits = (phase == PH_DIGITS) || (phase == PH_SIGN && !is_sign_char);
  assign dc_eff    = (phase == PH_SIGN) ? '0 : digit_count;
  assign acc_eff   = (phase == PH_SIGN) ? '0 : param_accum;
  assign sign_eff  = (phase == PH_SIGN) ? SIGN_NONE : sign_mode;

  // accum * 10 + digit, saturating at the top of the parameter range
  assign acc_grow = {1'b0, acc_eff, 3'b000} + {3'b000, acc_eff, 1'b0}
                  + {{(PARAM_W+4-4){1'b0}}, c[3:0]};

  // a command with no digits reissues the last one
  assign cmd_letter = (dc_eff != '0) ? c : last_letter;
  assign cmd_param  = (dc_eff != '0) ? acc_eff : last_param;

  scmd_exec u_exec (
    .letter           (cmd_letter),
    .param            (cmd_param),
    .sign             (sign_eff),
    .pitch_level      (pitch_level),
    .rate_level       (rate_level),
    .result           (cmd_res),
    .pitch_level_next (cmd_pitch_next),
    .rate_level_next  (cmd_rate_next)
  );

  always_comb begin
    phase_next       = phase;
    sign_mode_next   = sign_mode;
    digit_count_next = digit_count;
    param_accum_next = param_accum;
    last_letter_next = last_letter;
    last_param_next  = last_param;
    pitch_level_next = pitch_level;
    rate_level_next  = rate_level;
    res_valid        = 1'b0;
    res              = '{kind: KIND_TEXT, text_byte: 8'h00, setting: 8'sd0};

    if (phase == PH_SIGN && is_sign_char) begin
      sign_mode_next   = (c == BYTE_PLUS) ? SIGN_PLUS : SIGN_MINUS;
      digit_count_next = '0;
      param_accum_next = '0;
      phase_next       = PH_DIGITS;
    end else if (in_digits) begin
      sign_mode_next   = sign_eff;
      digit_count_next = dc_eff;
      param_accum_next = acc_eff;
      if (is_digit && dc_eff < DCNT_W'(MAX_DIGITS)) begin
        param_accum_next = (acc_grow > {4'b0000, PARAM_MAX}) ? PARAM_MAX
                         : acc_grow[PARAM_W-1:0];
        digit_count_next = dc_eff + DCNT_W'(1);
        phase_next       = PH_DIGITS;
      end else begin
        // this byte is the command letter
        if (dc_eff != '0) begin
          last_letter_next = c;
          last_param_next  = acc_eff;
        end
        phase_next       = PH_TEXT;
        pitch_level_next = cmd_pitch_next;
        rate_level_next  = cmd_rate_next;
        res_valid        = 1'b1;
        res              = cmd_res;
      end
    end else begin
      phase_next = PH_TEXT;
      if (c == BYTE_STOP) begin
        res_valid = 1'b1;
        res       = '{kind: KIND_STOP, text_byte: 8'h00, setting: 8'sd0};
      end else if (c == BYTE_CMD) begin
        phase_next = PH_SIGN;
      end else begin
        res_valid = 1'b1;
        res       = '{kind: KIND_TEXT, text_byte: c, setting: 8'sd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TEXT;
      sign_mode   <= SIGN_NONE;
      digit_count <= '0;
      param_accum <= '0;
      last_letter <= 8'h00;
      last_param  <= '0;
      pitch_level <= LEVEL_MID;
      rate_level  <= LEVEL_MID;
      m_tvalid    <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res_valid;
      if (in_valid) begin
        phase       <= phase_next;
        sign_mode   <= sign_mode_next;
        digit_count <= digit_count_next;
        param_accum <= param_accum_next;
        last_letter <= last_letter_next;
        last_param  <= last_param_next;
        pitch_level <= pitch_level_next;
        rate_level  <= rate_level_next;
      end
    end
    if (advance && in_valid && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {out_res.setting, out_res.text_byte};

  // levels never leave their saturated ranges
  assert property (@(posedge clk) disable iff (rst)
    pitch_level <= PITCH_TOP && rate_level <= RATE_TOP)
    else $error("pitch or rate level out of range");

  // the digit counter stops at the maximum digit count
  assert property (@(posedge clk) disable iff (rst)
    digit_count <= DCNT_W'(MAX_DIGITS))
    else $error("digit count beyond maximum");

  // a held input byte is not dropped or changed while the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input register lost a byte while stalled");

  // state is frozen while the output register is blocked
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pitch_level) && $stable(rate_level) && $stable(last_letter))
    else $error("parser state moved while stalled");

endmodule
